// File: hw/rtl/lsscl_pkg.sv
`default_nettype none
package lsscl_pkg;

  localparam int DATA_W = 32;
  localparam int N_IN   = 12;
  localparam int IN_W   = N_IN * DATA_W;
  localparam int OUT_W  = 33;
  localparam int OUT_TW = 40;

  localparam int DIV_STEPS = 32;
  localparam int SQ_STEPS  = 33;

  // pipeline register positions
  localparam int ST_S1  = 0;
  localparam int ST_I1  = ST_S1 + DIV_STEPS + 1;
  localparam int ST_I2  = ST_I1 + 1;
  localparam int ST_I3  = ST_I2 + 1;
  localparam int ST_Q1  = ST_I3 + 1;
  localparam int ST_Q2  = ST_Q1 + 1;
  localparam int ST_Q3  = ST_Q2 + 1;
  localparam int ST_C1  = ST_Q3 + SQ_STEPS + 1;
  localparam int ST_C2  = ST_C1 + 1;
  localparam int ST_C3  = ST_C2 + 1;
  localparam int N_ST   = ST_C3 + 1;

  localparam logic MODE_CLIP = 1'b0;
  localparam logic MODE_TWOX = 1'b1;

  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_LEN  = 2'd1;
  localparam logic [1:0] RES_FRAC = 2'd2;

  localparam logic [32:0] FRAC_ONE = 33'h1_0000_0000;
  localparam logic [33:0] OUT_MAX  = 34'h1_FFFF_FFFF;

  // x, y, psi
  typedef logic [2:0][DATA_W-1:0] pt_t;

  typedef struct packed {
    logic [32:0] r;
    logic [32:0] d;
    logic [31:0] q;
    logic        one;
    logic        zero;
  } div_t;

  typedef struct packed {
    pt_t  p;
    pt_t  q;
    div_t dv;
  } lane_t;

  typedef struct packed {
    pt_t         p0;
    pt_t         q0;
    pt_t         p1;
    pt_t         q1;
    logic        mode;
    logic        fz;
    logic [15:0] eps;
  } side_t;

  typedef struct packed {
    logic [65:0] s;
    logic [34:0] rem;
    logic [32:0] root;
  } sq_t;

  function automatic logic [1:0] nxt(logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : 2'(i + 2'd1);
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] a);
    return a[31] ? 32'(-a) : a;
  endfunction

  function automatic logic [32:0] mag33(logic [32:0] a);
    return a[32] ? 33'(-a) : a;
  endfunction

  function automatic div_t div_step(div_t s);
    div_t        o;
    logic [33:0] r2;
    o  = s;
    r2 = {s.r, 1'b0};
    if (r2 >= {1'b0, s.d}) begin
      o.r = 33'(r2 - {1'b0, s.d});
      o.q = {s.q[30:0], 1'b1};
    end else begin
      o.r = r2[32:0];
      o.q = {s.q[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [32:0] frac_val(div_t s);
    if (s.zero) return 33'd0;
    if (s.one) return FRAC_ONE;
    return {1'b0, s.q};
  endfunction

  function automatic sq_t sq_step(sq_t s);
    sq_t         o;
    logic [36:0] rs;
    logic [36:0] tr;
    o  = s;
    rs = {s.rem, s.s[65:64]};
    tr = {2'b00, s.root, 2'b01};
    if (rs >= tr) begin
      o.rem  = 35'(rs - tr);
      o.root = {s.root[31:0], 1'b1};
    end else begin
      o.rem  = rs[34:0];
      o.root = {s.root[31:0], 1'b0};
    end
    o.s = {s.s[63:0], 2'b00};
    return o;
  endfunction

  function automatic lane_t mk_edge(pt_t a, pt_t b, logic [31:0] va, logic [31:0] vb);
    lane_t       o;
    logic [31:0] na;
    logic [31:0] nb;
    na        = mag32(va);
    nb        = mag32(vb);
    o.p       = a;
    o.q       = b;
    o.dv.r    = {1'b0, na};
    o.dv.d    = {1'b0, na} + {1'b0, nb};
    o.dv.q    = '0;
    o.dv.zero = (o.dv.d == 33'd0);
    o.dv.one  = ({1'b0, na} >= o.dv.d);
    return o;
  endfunction

  function automatic lane_t mk_pseudo(pt_t a);
    lane_t o;
    o.p       = a;
    o.q       = a;
    o.dv.r    = '0;
    o.dv.d    = 33'd1;
    o.dv.q    = '0;
    o.dv.zero = 1'b0;
    o.dv.one  = 1'b0;
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/level_set_segment_clip_length.sv
`default_nettype none
// Clipped zero-curve length per triangle. Each item on s_tdata carries three
// vertices and phi/psi per vertex (signed Q16.16); one result item per input
// carries the length of the phi = 0 segment where psi < 0, unsigned Q17.16.
// One item enters per clock unless the pipe is stalled. The 32-step crossing
// fraction dividers and the 33-step square root follow each other in the pipe;
// the psi clip divider runs beside the square root. The whole pipe holds on a
// stall only when its last stage and the output register are both full.
// zero_threshold is written through cfg_we/cfg_wdata.
module level_set_segment_clip_length (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [15:0]                 cfg_wdata,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // x_a, y_a, x_b, y_b, x_c, y_c, curve_a, curve_b, curve_c, clip_a, clip_b, clip_c
  input  wire logic [lsscl_pkg::IN_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // seg_length, zero fill
  output logic [lsscl_pkg::OUT_TW-1:0]     m_tdata
);

  logic [15:0] zero_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= '0;
    end else if (cfg_we) begin
      zero_threshold <= cfg_wdata;
    end
  end

  logic                       en;
  logic [lsscl_pkg::N_ST-1:0] vld;
  logic                       out_valid;
  logic [32:0]                out_len;

  assign en       = !vld[lsscl_pkg::ST_C3] || !out_valid || m_tready;
  assign s_tready = en;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[lsscl_pkg::N_ST-2:0], s_tvalid};
    end
  end

  // classify and set up the two lanes
  lsscl_pkg::pt_t     vt [0:2];
  logic        [31:0] cv [0:2];
  logic signed [32:0] epsv, neps, vs, ws;
  logic        [2:0]  pos, neg, zr, wge, cr;
  logic        [1:0]  nz, ic1, ic2;
  lsscl_pkg::lane_t   ed [0:2];
  lsscl_pkg::lane_t   l0n, l1n;
  logic               moden, fzn;

  always_comb begin
    epsv = $signed({17'b0, zero_threshold});
    neps = -epsv;
    for (int i = 0; i < 3; i++) begin
      vt[i][0] = s_tdata[64*i +: 32];
      vt[i][1] = s_tdata[64*i+32 +: 32];
      vt[i][2] = s_tdata[32*(9+i) +: 32];
      cv[i]    = s_tdata[32*(6+i) +: 32];
    end
    vs = '0;
    ws = '0;
    for (int i = 0; i < 3; i++) begin
      vs     = $signed({cv[i][31], cv[i]});
      ws     = $signed({vt[i][2][31], vt[i][2]});
      pos[i] = vs > epsv;
      neg[i] = vs < neps;
      zr[i]  = !pos[i] && !neg[i];
      wge[i] = ws >= neps;
    end
    for (int k = 0; k < 3; k++) begin
      ed[k] = lsscl_pkg::mk_edge(vt[lsscl_pkg::nxt(2'(k))],
                                 vt[lsscl_pkg::nxt(lsscl_pkg::nxt(2'(k)))],
                                 cv[lsscl_pkg::nxt(2'(k))],
                                 cv[lsscl_pkg::nxt(lsscl_pkg::nxt(2'(k)))]);
      cr[k] = pos[lsscl_pkg::nxt(2'(k))] != pos[lsscl_pkg::nxt(lsscl_pkg::nxt(2'(k)))];
    end
    nz  = 2'($countones(zr));
    ic1 = zr[0] ? 2'd0 : (zr[1] ? 2'd1 : 2'd2);
    ic2 = (zr[0] && zr[1]) ? 2'd1 : 2'd2;
    fzn = (nz == 2'd3) || ((nz != 2'd2) && (!(|pos) || !(|neg)))
          || ((nz == 2'd0) && (&wge));
    moden = lsscl_pkg::MODE_CLIP;
    case (nz)
      2'd2: begin
        l0n = lsscl_pkg::mk_pseudo(vt[ic1]);
        l1n = lsscl_pkg::mk_pseudo(vt[ic2]);
      end
      2'd1: begin
        l0n = lsscl_pkg::mk_pseudo(vt[ic1]);
        l1n = ed[ic1];
      end
      2'd0: begin
        moden = lsscl_pkg::MODE_TWOX;
        l0n   = cr[0] ? ed[0] : ed[1];
        l1n   = (cr[0] && cr[1]) ? ed[1] : ed[2];
      end
      default: begin
        l0n = lsscl_pkg::mk_pseudo(vt[0]);
        l1n = lsscl_pkg::mk_pseudo(vt[0]);
      end
    endcase
  end

  // crossing fraction dividers
  lsscl_pkg::side_t sd  [0:lsscl_pkg::DIV_STEPS];
  lsscl_pkg::div_t  dl0 [0:lsscl_pkg::DIV_STEPS];
  lsscl_pkg::div_t  dl1 [0:lsscl_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].p0   <= l0n.p;
      sd[0].q0   <= l0n.q;
      sd[0].p1   <= l1n.p;
      sd[0].q1   <= l1n.q;
      sd[0].mode <= moden;
      sd[0].fz   <= fzn;
      sd[0].eps  <= zero_threshold;
      dl0[0]     <= l0n.dv;
      dl1[0]     <= l1n.dv;
      for (int k = 1; k <= lsscl_pkg::DIV_STEPS; k++) begin
        sd[k]  <= sd[k-1];
        dl0[k] <= lsscl_pkg::div_step(dl0[k-1]);
        dl1[k] <= lsscl_pkg::div_step(dl1[k-1]);
      end
    end
  end

  // interpolation
  lsscl_pkg::pt_t ip [0:1];
  lsscl_pkg::pt_t iq [0:1];
  logic    [32:0] idf [0:1][0:2];

  lsscl_pkg::pt_t i1_p   [0:1];
  logic           i1_neg [0:1][0:2];
  logic    [32:0] i1_mag [0:1][0:2];
  logic    [32:0] i1_f   [0:1];
  logic           i1_mode, i1_fz;
  logic    [15:0] i1_eps;

  lsscl_pkg::pt_t i2_p    [0:1];
  logic           i2_neg  [0:1][0:2];
  logic    [32:0] i2_mag  [0:1][0:2];
  logic    [63:0] i2_prod [0:1][0:2];
  logic    [32:0] i2_f    [0:1];
  logic           i2_mode, i2_fz;
  logic    [15:0] i2_eps;

  logic    [32:0] i3s [0:1][0:2];
  lsscl_pkg::pt_t i3_c [0:1];
  logic           i3_mode, i3_fz;
  logic    [15:0] i3_eps;

  always_comb begin
    ip[0] = sd[lsscl_pkg::DIV_STEPS].p0;
    iq[0] = sd[lsscl_pkg::DIV_STEPS].q0;
    ip[1] = sd[lsscl_pkg::DIV_STEPS].p1;
    iq[1] = sd[lsscl_pkg::DIV_STEPS].q1;
    for (int j = 0; j < 2; j++) begin
      for (int c = 0; c < 3; c++) begin
        idf[j][c] = {iq[j][c][31], iq[j][c]} - {ip[j][c][31], ip[j][c]};
        if (i2_f[j][32]) begin
          i3s[j][c] = i2_mag[j][c];
        end else if (i2_mag[j][c][32]) begin
          i3s[j][c] = {1'b0, i2_f[j][31:0]};
        end else begin
          i3s[j][c] = {1'b0, i2_prod[j][c][63:32]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i1_f[0] <= lsscl_pkg::frac_val(dl0[lsscl_pkg::DIV_STEPS]);
      i1_f[1] <= lsscl_pkg::frac_val(dl1[lsscl_pkg::DIV_STEPS]);
      i1_mode <= sd[lsscl_pkg::DIV_STEPS].mode;
      i1_fz   <= sd[lsscl_pkg::DIV_STEPS].fz;
      i1_eps  <= sd[lsscl_pkg::DIV_STEPS].eps;
      i2_f    <= i1_f;
      i2_p    <= i1_p;
      i2_neg  <= i1_neg;
      i2_mag  <= i1_mag;
      i2_mode <= i1_mode;
      i2_fz   <= i1_fz;
      i2_eps  <= i1_eps;
      i3_mode <= i2_mode;
      i3_fz   <= i2_fz;
      i3_eps  <= i2_eps;
      for (int j = 0; j < 2; j++) begin
        i1_p[j] <= ip[j];
        for (int c = 0; c < 3; c++) begin
          i1_neg[j][c]  <= idf[j][c][32];
          i1_mag[j][c]  <= lsscl_pkg::mag33(idf[j][c]);
          i2_prod[j][c] <= i1_mag[j][c][31:0] * i1_f[j][31:0];
          i3_c[j][c]    <= i2_neg[j][c]
                           ? 32'({i2_p[j][c][31], i2_p[j][c]} - i3s[j][c])
                           : 32'({i2_p[j][c][31], i2_p[j][c]} + i3s[j][c]);
        end
      end
    end
  end

  // segment length squares and clip decision
  logic        [32:0] qdf [0:1];
  logic signed [32:0] ca, cb, qe, qne;
  logic        [1:0]  qcode;
  logic               qinv;
  logic        [31:0] qna, qnb;
  lsscl_pkg::div_t    qdv;

  logic        [32:0] q1_m [0:1];
  lsscl_pkg::div_t    q1_cd;
  logic        [1:0]  q1_code;
  logic               q1_inv;

  logic        [63:0] q2_l2 [0:1];
  logic               q2_h  [0:1];
  lsscl_pkg::div_t    q2_cd;
  logic        [1:0]  q2_code;
  logic               q2_inv;

  logic        [65:0] q3sum;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      qdf[c] = {i3_c[1][c][31], i3_c[1][c]} - {i3_c[0][c][31], i3_c[0][c]};
    end
    ca  = $signed({i3_c[0][2][31], i3_c[0][2]});
    cb  = $signed({i3_c[1][2][31], i3_c[1][2]});
    qe  = $signed({17'b0, i3_eps});
    qne = -qe;
    qinv = 1'b0;
    if (i3_mode == lsscl_pkg::MODE_CLIP) begin
      if (ca < qe && cb < qe) begin
        qcode = lsscl_pkg::RES_LEN;
      end else if (ca > qne && cb > qne) begin
        qcode = lsscl_pkg::RES_ZERO;
      end else begin
        qcode = lsscl_pkg::RES_FRAC;
        qinv  = cb[32];
      end
    end else begin
      if (ca >= qne && cb >= qne) begin
        qcode = lsscl_pkg::RES_ZERO;
      end else if (ca <= qe && cb <= qe) begin
        qcode = lsscl_pkg::RES_LEN;
      end else begin
        qcode = lsscl_pkg::RES_FRAC;
        qinv  = !ca[32];
      end
    end
    if (i3_fz) begin
      qcode = lsscl_pkg::RES_ZERO;
    end
    qna      = lsscl_pkg::mag32(i3_c[0][2]);
    qnb      = lsscl_pkg::mag32(i3_c[1][2]);
    qdv.r    = {1'b0, qna};
    qdv.d    = {1'b0, qna} + {1'b0, qnb};
    qdv.q    = '0;
    qdv.zero = (qdv.d == 33'd0);
    qdv.one  = ({1'b0, qna} >= qdv.d);
    q3sum = (q2_h[0] ? 66'h1_0000_0000_0000_0000 : {2'b00, q2_l2[0]})
          + (q2_h[1] ? 66'h1_0000_0000_0000_0000 : {2'b00, q2_l2[1]});
  end

  // square root and clip fraction, side by side
  lsscl_pkg::sq_t  sq   [0:lsscl_pkg::SQ_STEPS];
  lsscl_pkg::div_t cd   [0:lsscl_pkg::SQ_STEPS];
  logic [1:0]      ccd  [0:lsscl_pkg::SQ_STEPS];
  logic            cinv [0:lsscl_pkg::SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        q1_m[c]  <= lsscl_pkg::mag33(qdf[c]);
        q2_l2[c] <= q1_m[c][31:0] * q1_m[c][31:0];
        q2_h[c]  <= q1_m[c][32];
      end
      q1_cd     <= qdv;
      q1_code   <= qcode;
      q1_inv    <= qinv;
      q2_cd     <= q1_cd;
      q2_code   <= q1_code;
      q2_inv    <= q1_inv;
      sq[0].s   <= q3sum;
      sq[0].rem <= '0;
      sq[0].root <= '0;
      cd[0]     <= q2_cd;
      ccd[0]    <= q2_code;
      cinv[0]   <= q2_inv;
      for (int k = 1; k <= lsscl_pkg::SQ_STEPS; k++) begin
        sq[k]   <= lsscl_pkg::sq_step(sq[k-1]);
        cd[k]   <= (k <= lsscl_pkg::DIV_STEPS) ? lsscl_pkg::div_step(cd[k-1]) : cd[k-1];
        ccd[k]  <= ccd[k-1];
        cinv[k] <= cinv[k-1];
      end
    end
  end

  // clip scaling
  logic [32:0] cfq;
  logic [32:0] c1_len, c1_f;
  logic [1:0]  c1_code;
  logic [63:0] c2_prod;
  logic [31:0] c2_hi;
  logic        c2_fone;
  logic [32:0] c2_len;
  logic [1:0]  c2_code;
  logic [33:0] c3fr, c3r;
  logic [32:0] c3_len;

  always_comb begin
    cfq  = lsscl_pkg::frac_val(cd[lsscl_pkg::SQ_STEPS]);
    c3fr = c2_fone ? {1'b0, c2_len} : ({2'b00, c2_prod[63:32]} + {2'b00, c2_hi});
    case (c2_code)
      lsscl_pkg::RES_LEN:  c3r = {1'b0, c2_len};
      lsscl_pkg::RES_FRAC: c3r = c3fr;
      default:             c3r = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_len  <= sq[lsscl_pkg::SQ_STEPS].root;
      c1_f    <= cinv[lsscl_pkg::SQ_STEPS] ? 33'(lsscl_pkg::FRAC_ONE - cfq) : cfq;
      c1_code <= ccd[lsscl_pkg::SQ_STEPS];
      c2_prod <= c1_len[31:0] * c1_f[31:0];
      c2_hi   <= c1_len[32] ? c1_f[31:0] : 32'd0;
      c2_fone <= c1_f[32];
      c2_len  <= c1_len;
      c2_code <= c1_code;
      c3_len  <= (c3r > lsscl_pkg::OUT_MAX) ? lsscl_pkg::OUT_MAX[32:0] : c3r[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= vld[lsscl_pkg::ST_C3];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_len <= c3_len;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (vld[lsscl_pkg::ST_C3] && out_valid))
    else $error("input stalled with room in the pipe");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && m_tready && !vld[lsscl_pkg::ST_C3]) |=> !out_valid)
    else $error("output item appeared without a source");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    vld[lsscl_pkg::ST_C1] |-> (!c1_f[32] || (c1_f[31:0] == 32'd0)))
    else $error("clip fraction above one");
`endif

endmodule
`default_nettype wire

// File: bench/level_set_segment_clip_length_test.sv
`default_nettype none
module level_set_segment_clip_length_test;

  typedef logic [31:0] tri_t [12];

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
  localparam logic [32:0] LEN_MAX = 33'h1_FFFF_FFFF;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [15:0]                   cfg_wdata = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [lsscl_pkg::IN_W-1:0]    s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lsscl_pkg::OUT_TW-1:0]  m_tdata;

  logic [32:0] len_queue[$];
  logic [15:0] cur_eps = '0;
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;

  level_set_segment_clip_length DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] mag64(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // floor(a * f / 2^32)
  function automatic logic [63:0] scale_q32(logic [63:0] a, logic [63:0] f);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, f};
    return p[95:32];
  endfunction

  function automatic logic [63:0] ratio_q32(logic [63:0] n, logic [63:0] d);
    logic [127:0] q;
    if (d == 0) return 64'd0;
    if (n >= d) return Q32_ONE;
    q = {32'd0, n, 32'd0} / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic longint lerp(longint p, longint q, logic [63:0] f);
    longint d;
    longint s;
    d = q - p;
    s = longint'(scale_q32(mag64(d), f));
    return d < 0 ? p - s : p + s;
  endfunction

  function automatic logic [63:0] seg_dist(longint x1, longint y1, longint x2, longint y2);
    logic [127:0] sum;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  t;
    sum = {64'd0, mag64(x2 - x1)} * {64'd0, mag64(x2 - x1)} +
          {64'd0, mag64(y2 - y1)} * {64'd0, mag64(y2 - y1)};
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= sum) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] clip_len(longint a, longint b, logic [63:0] len,
                                           longint eps);
    logic [63:0] f;
    if (a < eps && b < eps) return len;
    if (a > -eps && b > -eps) return 64'd0;
    f = ratio_q32(mag64(a), mag64(a) + mag64(b));
    if (b < 0) f = Q32_ONE - f;
    return scale_q32(len, f);
  endfunction

  function automatic logic [32:0] predict_length(tri_t t, logic [15:0] th);
    longint      x[3], y[3], v[3], w[3], cx[2], cy[2], ps[2];
    longint      eps;
    int          npl, nmin, nz, ic1, ic2, j, i1, i2;
    logic [63:0] res, len, f;
    eps = longint'(th);
    npl = 0; nmin = 0; nz = 0; ic1 = 0; ic2 = 0; res = '0;
    for (int i = 0; i < 3; i++) begin
      x[i] = longint'(signed'(t[2*i]));
      y[i] = longint'(signed'(t[2*i+1]));
      v[i] = longint'(signed'(t[6+i]));
      w[i] = longint'(signed'(t[9+i]));
    end
    for (int i = 0; i < 3; i++) begin
      if (v[i] > eps) npl++;
      else if (v[i] < -eps) nmin++;
      else begin
        if (nz == 0) ic1 = i; else ic2 = i;
        nz++;
      end
    end
    if (nz == 3) begin
      res = '0;
    end else if (nz == 2) begin
      len = seg_dist(x[ic1], y[ic1], x[ic2], y[ic2]);
      res = clip_len(w[ic1], w[ic2], len, eps);
    end else if (npl == 0 || nmin == 0) begin
      res = '0;
    end else if (nz == 1) begin
      i1 = (ic1 + 1) % 3;
      i2 = (ic1 + 2) % 3;
      f = ratio_q32(mag64(v[i1]), mag64(v[i1]) + mag64(v[i2]));
      ps[0] = lerp(w[i1], w[i2], f);
      cx[0] = lerp(x[i1], x[i2], f);
      cy[0] = lerp(y[i1], y[i2], f);
      len = seg_dist(cx[0], cy[0], x[ic1], y[ic1]);
      res = clip_len(w[ic1], ps[0], len, eps);
    end else if (w[0] >= -eps && w[1] >= -eps && w[2] >= -eps) begin
      res = '0;
    end else begin
      j = 0;
      for (int i = 0; i < 3 && j < 2; i++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        if ((v[i1] > 0) != (v[i2] > 0)) begin
          f = ratio_q32(mag64(v[i1]), mag64(v[i1]) + mag64(v[i2]));
          cx[j] = lerp(x[i1], x[i2], f);
          cy[j] = lerp(y[i1], y[i2], f);
          ps[j] = lerp(w[i1], w[i2], f);
          j++;
        end
      end
      if (j == 2) begin
        len = seg_dist(cx[0], cy[0], cx[1], cy[1]);
        if (ps[0] >= -eps && ps[1] >= -eps) res = '0;
        else if (ps[0] <= eps && ps[1] <= eps) res = len;
        else begin
          f = ratio_q32(mag64(ps[0]), mag64(ps[0]) + mag64(ps[1]));
          res = ps[0] < 0 ? scale_q32(len, f) : scale_q32(len, Q32_ONE - f);
        end
      end
    end
    return res > 64'(LEN_MAX) ? LEN_MAX : res[32:0];
  endfunction

  task automatic send_item(tri_t t);
    s_tvalid <= 1'b1;
    for (int i = 0; i < 12; i++) s_tdata[i*32 +: 32] <= t[i];
    do @(posedge clk); while (!s_tready);
    len_queue.push_back(predict_length(t, cur_eps));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic send_tri(logic [31:0] xa, logic [31:0] ya, logic [31:0] xb,
                          logic [31:0] yb, logic [31:0] xc, logic [31:0] yc,
                          logic [31:0] ca, logic [31:0] cb, logic [31:0] cc,
                          logic [31:0] pa, logic [31:0] pb, logic [31:0] pc);
    tri_t t;
    t = '{xa, ya, xb, yb, xc, yc, ca, cb, cc, pa, pb, pc};
    send_item(t);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (len_queue.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] th);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= th;
    cur_eps    = th;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_level(int kind);
    logic [31:0] m;
    case (kind)
      0: begin
        m = $urandom_range(0, cur_eps);
        return $urandom_range(0, 1) ? 32'(-m) : m;
      end
      1: return 32'(cur_eps) + 32'd1 + $urandom_range(0, 24'hFF_FFFF);
      default: return 32'(-(32'(cur_eps) + 32'd1 + $urandom_range(0, 24'hFF_FFFF)));
    endcase
  endfunction

  function automatic logic [31:0] pick_coord(bit wide);
    if (wide) return $urandom;
    return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    bit   wide;
    int   shape;
    shape = $urandom_range(0, 9);
    wide  = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < 12; i++) t[i] = $urandom;
    if (shape != 0) begin
      for (int i = 0; i < 6; i++) t[i] = pick_coord(wide);
      for (int i = 6; i < 9; i++) t[i] = pick_level($urandom_range(0, 2));
      for (int i = 9; i < 12; i++)
        t[i] = $urandom_range(0, 3) == 0 ? pick_level(0) :
               pick_level($urandom_range(1, 2));
    end
    return t;
  endfunction

  task automatic test_directed();
    set_threshold(16'd0);
    // all three on the curve
    send_tri(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, -1, -1, -1);
    // edge on the curve, fully inside, fully outside, clipped, zero denominator
    send_tri(0, 0, 32'h30000, 32'h40000, 0, 32'h10000, 0, 0, 32'h10000,
             32'hFFFF0000, 32'hFFFF0000, 5);
    send_tri(0, 0, 32'h30000, 32'h40000, 0, 32'h10000, 0, 0, 32'h10000, 3, 4, 5);
    send_tri(0, 0, 32'h30000, 32'h40000, 0, 32'h10000, 0, 0, 32'hFFFF0000,
             32'hFFFF0000, 32'h30000, 0);
    send_tri(0, 0, 32'h30000, 32'h40000, 0, 32'h10000, 0, 0, 32'hFFFF0000, 0, 0, 7);
    // through one vertex, crossing and missing
    send_tri(0, 0, 32'h20000, 0, 0, 32'h20000, 0, 32'h10000, 32'hFFFF0000,
             32'hFFFF0000, 32'h10000, 32'hFFFE0000);
    send_tri(0, 0, 32'h20000, 0, 0, 32'h20000, 0, 32'h10000, 32'h20000,
             32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000);
    // crossing on two sides: psi all negative, all non-negative, mixed; no crossing
    send_tri(0, 0, 32'h40000, 0, 0, 32'h40000, 32'hFFFF0000, 32'h10000, 32'h10000,
             32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000);
    send_tri(0, 0, 32'h40000, 0, 0, 32'h40000, 32'hFFFF0000, 32'h10000, 32'h10000,
             0, 1, 2);
    send_tri(0, 0, 32'h40000, 0, 0, 32'h40000, 32'hFFFF0000, 32'h10000, 32'h10000,
             32'h10000, 32'hFFFF0000, 32'h20000);
    send_tri(0, 0, 32'h40000, 0, 0, 32'h40000, 32'h10000, 32'h20000, 32'h30000,
             32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000);
    // extremes, saturation
    send_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tri('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
    send_tri(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    set_threshold(16'hFFFF);
    // values within the threshold count as zero
    send_tri(0, 0, 32'h10000, 0, 0, 32'h10000, 32'hFFFF, 32'hFFFF0001, 0,
             32'hFFFF0001, 32'hFFFF, 0);
    send_tri(0, 0, 32'h50000, 0, 0, 32'h50000, 32'hFFFF, 32'h10000, 32'hFFFF0000,
             32'hFFFE0000, 32'h10000, 32'h20000);
    send_tri(0, 0, 32'h50000, 0, 0, 32'h50000, 32'h10000, 32'h10000, 32'hFFFE0000,
             32'hFFFF, 32'hFFFF, 32'hFFFF0001);
    send_tri(0, 0, 32'h50000, 0, 0, 32'h50000, 32'h10000, 32'h10000, 32'hFFFE0000,
             32'h10000, 32'hFFFE0000, 32'h8000);
  endtask

  task automatic test_random();
    logic [15:0] levels[5];
    levels = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 16'hFFFE)),
               16'($urandom_range(1, 255))};
    for (int p = 0; p < 5; p++) begin
      set_threshold(levels[p]);
      gaps_on = (p != 2);
      for (int n = 0; n < 310; n++) begin
        if (n == 150) wait_drained();
        send_item(random_tri());
      end
    end
    gaps_on = 1'b1;
  endtask

  // receiver stall pattern changes each time the low eight bits of rx_cycle are zero
  int unsigned rx_cycle = 0;
  int          rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[7:0] == 8'd0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rx_cycle[4:0] < 5'd20);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (len_queue.size() == 0) begin
        $display("%0t: unexpected result seg_length=%h", $time,
                 m_tdata[lsscl_pkg::OUT_W-1:0]);
        errors++;
      end else if (m_tdata[lsscl_pkg::OUT_W-1:0] !== len_queue[0]) begin
        $display("%0t: seg_length expected %h actual %h", $time, len_queue[0],
                 m_tdata[lsscl_pkg::OUT_W-1:0]);
        errors++;
        void'(len_queue.pop_front());
      end else begin
        void'(len_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && len_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: level_set_segment_clip_length.f
hw/rtl/lsscl_pkg.sv
hw/rtl/level_set_segment_clip_length.sv
bench/level_set_segment_clip_length_test.sv
